// ===== hw/rtl/colormap_entry_generator_macros.svh =====
// Assertion macros shared by the colormap entry generator checkers.
`ifndef COLORMAP_ENTRY_GENERATOR_MACROS_SVH
`define COLORMAP_ENTRY_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CMEG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("colormap entry generator check failed");

// Next-cycle implication, disabled while reset is high.
`define CMEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("colormap entry generator check failed");

// Next-cycle implication that is checked through reset as well.
`define CMEG_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("colormap entry generator check failed");

`endif

// ===== hw/rtl/cmeg_pkg.sv =====
// Shared types, widths and the ramp node table of the colormap entry generator.
package cmeg_pkg;

   localparam int IndexWidth = 16;
   localparam int ColorWidth = 8;
   localparam int TableRows  = 8;
   localparam int RowW       = 3;

   typedef struct packed {
      logic [ColorWidth-1:0] red;
      logic [ColorWidth-1:0] green;
      logic [ColorWidth-1:0] blue;
   } rgb_type;

   localparam rgb_type Ramp [TableRows] = '{
      '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
      '{red: 8'd105, green: 8'd145, blue: 8'd2},
      '{red: 8'd0,   green: 8'd255, blue: 8'd29},
      '{red: 8'd180, green: 8'd255, blue: 8'd0},
      '{red: 8'd255, green: 8'd215, blue: 8'd6},
      '{red: 8'd255, green: 8'd143, blue: 8'd1},
      '{red: 8'd255, green: 8'd69,  blue: 8'd0},
      '{red: 8'd255, green: 8'd0,   blue: 8'd0}
   };

endpackage

// ===== hw/rtl/cmeg_divider.sv =====
// Pipelined restoring divider that turns a clamped index into a ramp position.
module cmeg_divider #(
   parameter int NODE_COUNT    = 8,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [cmeg_pkg::IndexWidth-1:0]                count,
   input  logic                                           in_valid,
   output logic                                           in_stall,
   input  logic [cmeg_pkg::IndexWidth-1:0]                in_index,
   input  logic                                           in_last,
   output logic                                           out_valid,
   input  logic                                           out_stall,
   output logic [FRACTION_BITS+$clog2(NODE_COUNT)-1:0]    out_position,
   output logic                                           out_last
);
   import cmeg_pkg::*;

   localparam int NodeW = $clog2(NODE_COUNT);
   localparam int QuoW  = FRACTION_BITS + NodeW;
   localparam int ProdW = IndexWidth + NodeW;
   localparam int DvdW  = ProdW + FRACTION_BITS;

   logic                  valid_ff [QuoW+1];
   logic                  last_ff  [QuoW+1];
   logic [IndexWidth-1:0] rem_ff   [QuoW+1];
   logic [QuoW-1:0]       work_ff  [QuoW+1];
   logic [QuoW:0]         adv;

   logic [ProdW-1:0]      scaled;
   logic [DvdW-1:0]       dividend;

   assign scaled   = ProdW'(in_index) * ProdW'(NODE_COUNT - 1);
   assign dividend = {scaled, {FRACTION_BITS{1'b0}}};

   assign adv[QuoW] = !valid_ff[QuoW] || !out_stall;
   assign in_stall  = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (adv[0]) begin
         last_ff[0] <= in_last;
         rem_ff[0]  <= dividend[DvdW-1:QuoW];
         work_ff[0] <= dividend[QuoW-1:0];
      end
   end

   for (genvar k = 1; k <= QuoW; k++) begin : g_step
      logic [IndexWidth:0]   trial;
      logic                  fits;
      logic [IndexWidth-1:0] rem_in;
      logic [QuoW-1:0]       work_in;

      if (k < QuoW) begin : g_adv
         assign adv[k-1] = !valid_ff[k-1] || adv[k];
      end else begin : g_adv_last
         assign adv[k-1] = !valid_ff[k-1] || adv[k];
      end

      always_comb begin
         trial   = {rem_ff[k-1], work_ff[k-1][QuoW-1]};
         fits    = trial >= {1'b0, count};
         rem_in  = fits ? IndexWidth'(trial - {1'b0, count}) : trial[IndexWidth-1:0];
         work_in = {work_ff[k-1][QuoW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (adv[k]) begin
            last_ff[k] <= last_ff[k-1];
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
         end
      end
   end

   assign out_valid    = valid_ff[QuoW];
   assign out_position = work_ff[QuoW];
   assign out_last     = last_ff[QuoW];

endmodule

// ===== hw/rtl/colormap_entry_generator.sv =====
// Top level of the colormap entry generator: index in, blended ramp colour out.
//
// Each req_ beat carries one colormap index; each rsp_ beat carries that
// entry's red, green and blue on a blue-to-red ramp of NODE_COUNT nodes.
// Indexes at or above the entry count are clamped to the final entry, and
// the final entry takes its node's colour without blending.
// The user must write the entry count through csr_write_enable and
// csr_write_data only while no beat is in flight; the block itself does not
// enforce this. Zero counts as one. Reset sets it to 256. The division of
// the scaled index by the entry count takes one pipeline stage per position
// bit. One beat is taken every cycle while req_stall is low.
// When rsp_stall holds the output, the stages behind it keep filling until
// every stage holds a beat, and only then does req_stall rise.
// Reset empties the pipeline; beats in flight are dropped.
module colormap_entry_generator #(
   parameter int NODE_COUNT    = 8,
   parameter int FRACTION_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cmeg_pkg::IndexWidth-1:0] req_color_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cmeg_pkg::ColorWidth-1:0] rsp_red,
   output logic [cmeg_pkg::ColorWidth-1:0] rsp_green,
   output logic [cmeg_pkg::ColorWidth-1:0] rsp_blue,
   input  logic                            csr_write_enable,
   input  logic [cmeg_pkg::IndexWidth-1:0] csr_write_data
);
   import cmeg_pkg::*;

   localparam int NodeW = $clog2(NODE_COUNT);
   localparam int QuoW  = FRACTION_BITS + NodeW;
   localparam int WgtW  = FRACTION_BITS + 1;
   localparam int ProdW = ColorWidth + WgtW;
   localparam int SumW  = ProdW + 1;
   localparam int ShW   = SumW - FRACTION_BITS;
   localparam logic [WgtW-1:0] One  = WgtW'(1) << FRACTION_BITS;
   localparam logic [SumW-1:0] Half = SumW'(1) << (FRACTION_BITS - 1);

   logic [IndexWidth-1:0] count_ff;
   logic [IndexWidth-1:0] count_m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= IndexWidth'(256);
         count_m1_ff <= IndexWidth'(255);
      end else if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            count_ff    <= IndexWidth'(1);
            count_m1_ff <= '0;
         end else begin
            count_ff    <= csr_write_data;
            count_m1_ff <= csr_write_data - IndexWidth'(1);
         end
      end
   end

   // Input stage: clamp the index and flag the final entry.
   logic                  valid_s1_ff;
   logic [IndexWidth-1:0] idx_s1_ff;
   logic                  last_s1_ff;
   logic                  adv_s1;
   logic                  div_in_stall;

   assign adv_s1    = !valid_s1_ff || !div_in_stall;
   assign req_stall = !adv_s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else if (adv_s1) begin
         valid_s1_ff <= req_valid;
      end
      if (adv_s1) begin
         idx_s1_ff  <= (req_color_index >= count_ff) ? count_m1_ff : req_color_index;
         last_s1_ff <= req_color_index >= count_m1_ff;
      end
   end

   logic            div_valid;
   logic            div_out_stall;
   logic [QuoW-1:0] div_position;
   logic            div_last;

   cmeg_divider #(
      .NODE_COUNT    (NODE_COUNT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .count        (count_ff),
      .in_valid     (valid_s1_ff),
      .in_stall     (div_in_stall),
      .in_index     (idx_s1_ff),
      .in_last      (last_s1_ff),
      .out_valid    (div_valid),
      .out_stall    (div_out_stall),
      .out_position (div_position),
      .out_last     (div_last)
   );

   // Blend stage: look up both nodes and form the weighted products.
   logic [4:0]               node_x;
   logic [4:0]               next_x;
   logic [RowW-1:0]          node_row;
   logic [RowW-1:0]          next_row;
   logic [FRACTION_BITS-1:0] frac;
   logic [WgtW-1:0]          weight_a;
   rgb_type                  color_a;
   rgb_type                  color_b;
   logic [ColorWidth-1:0]    chan_a [3];
   logic [ColorWidth-1:0]    chan_b [3];
   logic [ProdW-1:0]         prod_a_in [3];
   logic [ProdW-1:0]         prod_b_in [3];

   always_comb begin
      node_x   = 5'(div_position[QuoW-1:FRACTION_BITS]);
      next_x   = node_x + 5'd1;
      node_row = (node_x > 5'(TableRows - 1)) ? RowW'(TableRows - 1) : node_x[RowW-1:0];
      next_row = (next_x > 5'(TableRows - 1)) ? RowW'(TableRows - 1) : next_x[RowW-1:0];
      frac     = div_position[FRACTION_BITS-1:0];
      weight_a = One - {1'b0, frac};
      color_a  = Ramp[node_row];
      color_b  = Ramp[next_row];
      chan_a[0] = color_a.red;
      chan_a[1] = color_a.green;
      chan_a[2] = color_a.blue;
      chan_b[0] = color_b.red;
      chan_b[1] = color_b.green;
      chan_b[2] = color_b.blue;
      for (int ch = 0; ch < 3; ch++) begin
         prod_a_in[ch] = ProdW'(chan_a[ch]) * ProdW'(weight_a);
         prod_b_in[ch] = ProdW'(chan_b[ch]) * ProdW'(frac);
      end
   end

   logic             valid_m_ff;
   logic             last_m_ff;
   rgb_type          base_m_ff;
   logic [ProdW-1:0] prod_a_ff [3];
   logic [ProdW-1:0] prod_b_ff [3];
   logic             adv_m;
   logic             adv_o;

   assign adv_o         = !rsp_valid || !rsp_stall;
   assign adv_m         = !valid_m_ff || adv_o;
   assign div_out_stall = !adv_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m_ff <= 1'b0;
      end else if (adv_m) begin
         valid_m_ff <= div_valid;
      end
      if (adv_m) begin
         last_m_ff <= div_last;
         base_m_ff <= color_a;
         for (int ch = 0; ch < 3; ch++) begin
            prod_a_ff[ch] <= prod_a_in[ch];
            prod_b_ff[ch] <= prod_b_in[ch];
         end
      end
   end

   // Output stage: round, saturate and pick the unblended colour for the final entry.
   logic [SumW-1:0]       sum      [3];
   logic [ShW-1:0]        shifted  [3];
   logic [ColorWidth-1:0] blended  [3];
   logic [ColorWidth-1:0] base_ch  [3];
   logic [ColorWidth-1:0] chan_in  [3];

   always_comb begin
      base_ch[0] = base_m_ff.red;
      base_ch[1] = base_m_ff.green;
      base_ch[2] = base_m_ff.blue;
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch]     = SumW'(prod_a_ff[ch]) + SumW'(prod_b_ff[ch]) + Half;
         shifted[ch] = sum[ch][SumW-1:FRACTION_BITS];
         blended[ch] = (shifted[ch] > ShW'(255)) ? ColorWidth'(255)
                                                 : shifted[ch][ColorWidth-1:0];
         chan_in[ch] = last_m_ff ? base_ch[ch] : blended[ch];
      end
   end

   logic                  rsp_valid_ff;
   logic [ColorWidth-1:0] rsp_red_ff;
   logic [ColorWidth-1:0] rsp_green_ff;
   logic [ColorWidth-1:0] rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_o) begin
         rsp_valid_ff <= valid_m_ff;
      end
      if (adv_o) begin
         rsp_red_ff   <= chan_in[0];
         rsp_green_ff <= chan_in[1];
         rsp_blue_ff  <= chan_in[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

// ===== hw/rtl/cmeg_checker.sv =====
// Port-level checker for the colormap entry generator and its bind statement.
`include "colormap_entry_generator_macros.svh"

module cmeg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [cmeg_pkg::ColorWidth-1:0] rsp_red,
   input logic [cmeg_pkg::ColorWidth-1:0] rsp_green,
   input logic [cmeg_pkg::ColorWidth-1:0] rsp_blue,
   input logic                            csr_write_enable,
   input logic [cmeg_pkg::IndexWidth-1:0] csr_write_data
);
   import cmeg_pkg::*;

   logic [7:0]            pending_ff;
   logic [IndexWidth-1:0] entries_ff;
   logic                  req_beat;
   logic                  rsp_beat;
   logic                  single_entry;

   assign req_beat     = req_valid && !req_stall;
   assign rsp_beat     = rsp_valid && !rsp_stall;
   assign single_entry = (entries_ff == IndexWidth'(0)) || (entries_ff == IndexWidth'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         entries_ff <= IndexWidth'(256);
      end else begin
         pending_ff <= pending_ff + 8'(req_beat) - 8'(rsp_beat);
         if (csr_write_enable) begin
            entries_ff <= csr_write_data;
         end
      end
   end

   // The output is empty right after reset.
   `CMEG_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A result beat always belongs to an index beat taken earlier.
   `CMEG_ASSERT_IMPL(a_no_orphan, clock, reset, rsp_valid, pending_ff != 8'd0)

   // A stalled result beat stays in place.
   `CMEG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))

   // A one-entry colormap is the first ramp node only.
   `CMEG_ASSERT_IMPL(a_single_entry, clock, reset, rsp_valid && single_entry, rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd255)

endmodule

bind colormap_entry_generator cmeg_checker u_checker (.*);
